@@ hw/rtl/blr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_pkg: shared definitions for the line rasterizer
// Default sizes, command codes and the control word that travels from the
// command decoder to the pixel walker.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int OP_FIFO_DEPTH  = 4;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Classification of one command, fixed when the command is decoded.
    typedef struct packed {
        logic is_start;
        logic dir_x_neg;
        logic dir_y_neg;
        logic y_major;
    } blr_ctrl_t;

endpackage

@@ hw/rtl/blr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_front: command decoder
// Registers each incoming command, and for a start works out the step
// directions, the absolute deltas and the major axis.
// ----------------------------------------------------------------------------
module blr_front
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    output logic                  op_valid,
    input  logic                  op_ready,
    output blr_ctrl_t             op_ctrl,
    output logic [COORD_BITS-1:0] op_start_x,
    output logic [COORD_BITS-1:0] op_start_y,
    output logic [COORD_BITS-1:0] op_major,
    output logic [COORD_BITS-1:0] op_minor
);

    logic                  valid_reg;
    blr_ctrl_t             ctrl_reg, ctrl_next;
    logic [COORD_BITS-1:0] sx_reg, sy_reg, major_reg, minor_reg;
    logic [COORD_BITS-1:0] major_next, minor_next;
    logic [COORD_BITS-1:0] adx, ady;
    logic                  load;

    assign s_ready = !valid_reg || op_ready;
    assign load    = s_valid && s_ready;

    always_comb begin
        ctrl_next.is_start  = (s_command == CMD_START);
        ctrl_next.dir_x_neg = s_end_x < s_start_x;
        ctrl_next.dir_y_neg = s_end_y < s_start_y;
        adx = ctrl_next.dir_x_neg ? s_start_x - s_end_x : s_end_x - s_start_x;
        ady = ctrl_next.dir_y_neg ? s_start_y - s_end_y : s_end_y - s_start_y;
        // Equal deltas make y the major axis.
        ctrl_next.y_major = !(ady < adx);
        major_next = ctrl_next.y_major ? ady : adx;
        minor_next = ctrl_next.y_major ? adx : ady;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (load) begin
            ctrl_reg  <= ctrl_next;
            sx_reg    <= s_start_x;
            sy_reg    <= s_start_y;
            major_reg <= major_next;
            minor_reg <= minor_next;
        end
    end

    assign op_valid   = valid_reg;
    assign op_ctrl    = ctrl_reg;
    assign op_start_x = sx_reg;
    assign op_start_y = sy_reg;
    assign op_major   = major_reg;
    assign op_minor   = minor_reg;

endmodule

@@ hw/rtl/blr_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_fifo: command queue
// Small register-based FIFO between the decoder and the pixel walker.
// ----------------------------------------------------------------------------
module blr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The fill level never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("fifo fill level above depth");

endmodule

@@ hw/rtl/blr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_back: pixel walker
// Holds the running line, steps it one pixel per advance command and keeps
// the result in an output register.
// ----------------------------------------------------------------------------
module blr_back
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  blr_ctrl_t             op_ctrl,
    input  logic [COORD_BITS-1:0] op_start_x,
    input  logic [COORD_BITS-1:0] op_start_y,
    input  logic [COORD_BITS-1:0] op_major,
    input  logic [COORD_BITS-1:0] op_minor,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic                  m_last
);

    localparam int EW = COORD_BITS + 2;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [EW-1:0]  err_reg, err_next;
    logic signed [EW-1:0]  minor2_reg, minor2_next, diag_reg, diag_next;
    logic [COORD_BITS-1:0] steps_left_reg, steps_left_next;
    logic                  dxn_reg, dxn_next, dyn_reg, dyn_next;
    logic                  ymaj_reg, ymaj_next;
    logic                  line_active_reg, line_active_next;
    logic                  m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0] m_x_reg, m_y_reg;
    logic                  m_last_reg;
    logic                  pop, emit, step_x, step_y;

    assign op_ready = !m_valid_reg || m_ready;
    assign pop      = op_valid && op_ready;
    assign emit     = pop && (op_ctrl.is_start || line_active_reg);

    always_comb begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        err_next         = err_reg;
        minor2_next      = minor2_reg;
        diag_next        = diag_reg;
        steps_left_next  = steps_left_reg;
        dxn_next         = dxn_reg;
        dyn_next         = dyn_reg;
        ymaj_next        = ymaj_reg;
        line_active_next = line_active_reg;
        step_x           = 1'b0;
        step_y           = 1'b0;
        if (pop && op_ctrl.is_start) begin
            minor2_next      = {1'b0, op_minor, 1'b0};
            diag_next        = {1'b0, op_minor, 1'b0} - {1'b0, op_major, 1'b0};
            err_next         = {1'b0, op_minor, 1'b0} - {2'b00, op_major};
            cur_x_next       = op_start_x;
            cur_y_next       = op_start_y;
            steps_left_next  = op_major;
            dxn_next         = op_ctrl.dir_x_neg;
            dyn_next         = op_ctrl.dir_y_neg;
            ymaj_next        = op_ctrl.y_major;
            line_active_next = (op_major != '0);
        end else if (emit) begin
            if (err_reg[EW-1]) begin
                // Negative error: only the major axis moves.
                err_next = err_reg + minor2_reg;
                step_x   = !ymaj_reg;
                step_y   = ymaj_reg;
            end else begin
                err_next = err_reg + diag_reg;
                step_x   = 1'b1;
                step_y   = 1'b1;
            end
            if (step_x) begin
                cur_x_next = dxn_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (step_y) begin
                cur_y_next = dyn_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
            steps_left_next  = steps_left_reg - 1'b1;
            line_active_next = (steps_left_next != '0);
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            steps_left_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            line_active_reg <= line_active_next;
            steps_left_reg  <= steps_left_next;
            m_valid_reg     <= m_valid_next;
        end
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        err_reg    <= err_next;
        minor2_reg <= minor2_next;
        diag_reg   <= diag_next;
        dxn_reg    <= dxn_next;
        dyn_reg    <= dyn_next;
        ymaj_reg   <= ymaj_next;
        if (emit) begin
            m_x_reg    <= cur_x_next;
            m_y_reg    <= cur_y_next;
            m_last_reg <= !line_active_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pixel_x = m_x_reg;
    assign m_pixel_y = m_y_reg;
    assign m_last    = m_last_reg;

    // A line is running exactly while pixels remain.
    a_active_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        line_active_reg == (steps_left_reg != '0))
        else $error("line_active out of step with steps_left");

    // The pending pixel is flagged last exactly when its line has ended.
    a_last_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == !line_active_reg))
        else $error("last flag disagrees with line state");

    // An advance with no running line produces no new pixel.
    a_no_idle_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !op_ctrl.is_start && !line_active_reg && m_ready) |=> !m_valid_reg)
        else $error("pixel emitted without an active line");

endmodule

@@ hw/rtl/bresenham_line_rasterizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer: integer line rasterizer, all octants
// A start command loads two endpoints and emits the first pixel; each advance
// command emits the next pixel along the line and flags the final one.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    command, start_x, start_y, end_x, end_y
//   m_        out        m_valid/m_ready    pixel_x, pixel_y, last
//
// One command is taken per clock while s_ready is high; an accepted command
// passes the decoder register, the command queue and the output register.
// The walker does one error add and compare per clock, which sets the
// sustained rate at one pixel per clock while m_ready is high.
// Reset (aresetn low at a clock edge) empties the queue and ends any line.
// A stall on m_ holds the output register; the queue then fills and s_ready
// drops only when the queue and the decoder register are both occupied.
//
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic                  m_last
);

    // Queue entry: control word, start point, major and minor deltas.
    localparam int CTRL_W = $bits(blr_ctrl_t);
    localparam int ENTRY_W = CTRL_W + 4 * COORD_BITS;

    // Decoder to queue.
    logic                  dec_valid, dec_ready;
    blr_ctrl_t             dec_ctrl;
    logic [COORD_BITS-1:0] dec_start_x, dec_start_y, dec_major, dec_minor;

    // Queue to walker.
    logic                  q_valid, q_ready;
    logic [ENTRY_W-1:0]    q_data;
    blr_ctrl_t             q_ctrl;
    logic [COORD_BITS-1:0] q_start_x, q_start_y, q_major, q_minor;

    blr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_start_x  (s_start_x),
        .s_start_y  (s_start_y),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .op_valid   (dec_valid),
        .op_ready   (dec_ready),
        .op_ctrl    (dec_ctrl),
        .op_start_x (dec_start_x),
        .op_start_y (dec_start_y),
        .op_major   (dec_major),
        .op_minor   (dec_minor)
    );

    blr_fifo #(
        .WIDTH(ENTRY_W),
        .DEPTH(OP_FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (dec_valid),
        .wr_ready (dec_ready),
        .wr_data  ({dec_ctrl, dec_start_x, dec_start_y, dec_major, dec_minor}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    assign {q_ctrl, q_start_x, q_start_y, q_major, q_minor} = q_data;

    blr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_valid   (q_valid),
        .op_ready   (q_ready),
        .op_ctrl    (q_ctrl),
        .op_start_x (q_start_x),
        .op_start_y (q_start_y),
        .op_major   (q_major),
        .op_minor   (q_minor),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pixel_x  (m_pixel_x),
        .m_pixel_y  (m_pixel_y),
        .m_last     (m_last)
    );

endmodule
